// ===== rtl/arp_pkg.sv =====
// Shared types, codes and frame helpers for the ARP address resolver.
// Used by arp_address_resolver_core; no other dependencies.
`default_nettype none

package arp_pkg;

    localparam int TIMER_BITS = 16;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int TMO_W = 16;
    localparam int POS_W = 6;

    localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(41);
    localparam logic [POS_W-1:0] FRAME_LEN  = POS_W'(42);

    localparam logic [15:0] TMO_RESET = 16'd1000;

    // item commands
    localparam logic [1:0] CMD_RESOLVE = 2'd0;
    localparam logic [1:0] CMD_RX_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LOCAL_MAC  = 2'd0;
    localparam logic [1:0] REG_LOCAL_IP   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS = 2'd2;

    typedef enum logic [1:0] {
        KIND_REQ_BYTE = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_FAILED   = 2'd2
    } kind_t;

    // byte idx of a 48-bit word, idx 0 is the first wire byte
    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] w, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = w[47:40];
            3'd1:    b = w[39:32];
            3'd2:    b = w[31:24];
            3'd3:    b = w[23:16];
            3'd4:    b = w[15:8];
            3'd5:    b = w[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // byte idx of a 32-bit word, idx 0 is the first wire byte
    function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] w, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    // broadcast ARP request, byte at position p
    function automatic logic [7:0] request_byte(
        input logic [POS_W-1:0] p,
        input logic [MAC_W-1:0] mac,
        input logic [IP_W-1:0]  ip,
        input logic [IP_W-1:0]  tgt
    );
        logic [7:0]       b;
        logic [POS_W-1:0] off_src;
        logic [POS_W-1:0] off_sha;
        logic [POS_W-1:0] off_tpa;
        off_src = p - POS_W'(6);
        off_sha = p - POS_W'(22);
        off_tpa = p - POS_W'(38);
        case (p) inside
            [6'd0:6'd5]:   b = 8'hFF;
            [6'd6:6'd11]:  b = mac_byte(mac, off_src[2:0]);
            6'd12, 6'd16:  b = 8'h08;
            6'd13:         b = 8'h06;
            6'd15, 6'd21:  b = 8'h01;
            6'd18:         b = 8'd6;
            6'd19:         b = 8'd4;
            [6'd22:6'd27]: b = mac_byte(mac, off_sha[2:0]);
            [6'd28:6'd31]: b = ip_byte(ip, p[1:0]);
            [6'd38:6'd41]: b = ip_byte(tgt, off_tpa[1:0]);
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arp_address_resolver_core.sv =====
// ARP address resolver top level: request frame generator, reply checker,
// timeout counter and result register. Depends on arp_pkg.
`default_nettype none

// A resolve item (command 0) is taken and then produces the 42-byte
// broadcast ARP request, one result item per cycle of out_ready, plus
// a failure item when timeout_ms is zero; in_ready is low while that frame
// drains, so no new item is taken before its last item has entered the
// one-byte output register. Received frame bytes (command 1) and millisecond
// ticks (command 2) each yield at most one result; they are accepted every
// cycle while no request frame is being sent and the result register is free
// or being emptied. A reply frame is checked byte by byte as it streams in
// (ethertype 0x0806, opcode 2, sender IP equal to the wanted address, target
// IP equal to local_ip); the sender MAC is reported on the frame's last byte.
// Hardware and protocol type fields are not checked. Configuration writes are
// always accepted and should be made only while the block is idle.
module arp_address_resolver_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] wanted_ip,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_end,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       tx_byte,
    output logic             tx_end,
    output logic [47:0]      found_mac,
    output logic             run_last
);

    localparam int TB = arp_pkg::TIMER_BITS;
    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TB) - 64'd1);

    // configuration
    logic [47:0] local_mac_reg;
    logic [31:0] local_ip_reg;
    logic [15:0] timeout_ms_reg;

    // resolver state
    logic                       waiting_reg,     waiting_next;
    logic [31:0]                target_addr_reg, target_addr_next;
    logic [TB-1:0]              ticks_left_reg,  ticks_left_next;
    logic [arp_pkg::POS_W-1:0]  rx_pos_reg,      rx_pos_next;
    logic                       rx_ok_reg,       rx_ok_next;
    logic [47:0]                heard_mac_reg,   heard_mac_next;

    // request frame sequencer
    logic                       tx_active_reg,   tx_active_next;
    logic [arp_pkg::POS_W-1:0]  tx_pos_reg,      tx_pos_next;
    logic                       tx_fail_reg,     tx_fail_next;

    // result register
    logic                  out_valid_reg,  out_valid_next;
    arp_pkg::kind_t        kind_reg,       kind_next;
    logic [7:0]            tx_byte_reg,    tx_byte_next;
    logic                  tx_end_reg,     tx_end_next;
    logic [47:0]           found_mac_reg,  found_mac_next;
    logic                  run_last_reg,   run_last_next;

    logic        out_free;
    logic        in_fire;
    logic [31:0] tmo_wide;
    logic [TB-1:0] ticks_load;
    logic [arp_pkg::POS_W-1:0] rx_pos_inc;
    logic [arp_pkg::POS_W-1:0] off_tpa;
    logic        ok_chk;
    logic [47:0] mac_chk;
    logic [TB-1:0] ticks_dec;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !tx_active_reg && out_free;
    assign in_fire   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_end    = tx_end_reg;
    assign found_mac = found_mac_reg;
    assign run_last  = run_last_reg;

    // timeout loaded into the timer, saturating at its top value
    assign tmo_wide   = {16'd0, timeout_ms_reg};
    assign ticks_load = (tmo_wide > TIMER_MAX) ? TIMER_MAX[TB-1:0] : tmo_wide[TB-1:0];
    assign ticks_dec  = (ticks_left_reg != '0) ? ticks_left_reg - TB'(1) : ticks_left_reg;

    assign rx_pos_inc = rx_pos_reg + arp_pkg::POS_W'(1);
    assign off_tpa    = rx_pos_reg - arp_pkg::POS_W'(38);

    // per-position check of a received byte
    always_comb
    begin
        ok_chk  = rx_ok_reg;
        mac_chk = heard_mac_reg;
        case (rx_pos_reg) inside
            6'd12:         if (rx_byte != 8'h08) ok_chk = 1'b0;
            6'd13:         if (rx_byte != 8'h06) ok_chk = 1'b0;
            6'd20:         if (rx_byte != 8'h00) ok_chk = 1'b0;
            6'd21:         if (rx_byte != 8'h02) ok_chk = 1'b0;
            [6'd22:6'd27]: mac_chk = {heard_mac_reg[39:0], rx_byte};
            [6'd28:6'd31]:
                if (rx_byte != arp_pkg::ip_byte(target_addr_reg, rx_pos_reg[1:0]))
                    ok_chk = 1'b0;
            [6'd38:6'd41]:
                if (rx_byte != arp_pkg::ip_byte(local_ip_reg, off_tpa[1:0]))
                    ok_chk = 1'b0;
            default: ;
        endcase
    end

    always_comb
    begin
        waiting_next     = waiting_reg;
        target_addr_next = target_addr_reg;
        ticks_left_next  = ticks_left_reg;
        rx_pos_next      = rx_pos_reg;
        rx_ok_next       = rx_ok_reg;
        heard_mac_next   = heard_mac_reg;
        tx_active_next   = tx_active_reg;
        tx_pos_next      = tx_pos_reg;
        tx_fail_next     = tx_fail_reg;

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        tx_byte_next   = tx_byte_reg;
        tx_end_next    = tx_end_reg;
        found_mac_next = found_mac_reg;
        run_last_next  = run_last_reg;

        if (tx_active_reg && out_free) begin
            // next request byte, or the trailing failure on a zero timeout
            out_valid_next = 1'b1;
            found_mac_next = '0;
            if (tx_pos_reg == arp_pkg::FRAME_LEN) begin
                kind_next      = arp_pkg::KIND_FAILED;
                tx_byte_next   = 8'h00;
                tx_end_next    = 1'b0;
                run_last_next  = 1'b1;
                tx_active_next = 1'b0;
            end else begin
                kind_next    = arp_pkg::KIND_REQ_BYTE;
                tx_byte_next = arp_pkg::request_byte(tx_pos_reg, local_mac_reg,
                                                     local_ip_reg, target_addr_reg);
                tx_end_next  = (tx_pos_reg == arp_pkg::FRAME_LAST);
                run_last_next = (tx_pos_reg == arp_pkg::FRAME_LAST) && !tx_fail_reg;
                tx_pos_next  = tx_pos_reg + arp_pkg::POS_W'(1);
                if (tx_pos_reg == arp_pkg::FRAME_LAST && !tx_fail_reg)
                    tx_active_next = 1'b0;
            end
        end else if (in_fire) begin
            unique case (command)
                arp_pkg::CMD_RESOLVE:
                begin
                    target_addr_next = wanted_ip;
                    ticks_left_next  = ticks_load;
                    rx_pos_next      = '0;
                    rx_ok_next       = 1'b1;
                    heard_mac_next   = '0;
                    waiting_next     = (ticks_load != '0);
                    tx_fail_next     = (ticks_load == '0);
                    // byte 0 goes out now, the sequencer takes the rest
                    tx_active_next   = 1'b1;
                    tx_pos_next      = arp_pkg::POS_W'(1);
                    out_valid_next   = 1'b1;
                    kind_next        = arp_pkg::KIND_REQ_BYTE;
                    tx_byte_next     = 8'hFF;
                    tx_end_next      = 1'b0;
                    found_mac_next   = '0;
                    run_last_next    = 1'b0;
                end
                arp_pkg::CMD_RX_BYTE:
                begin
                    if (waiting_reg) begin
                        if (rx_pos_reg < arp_pkg::FRAME_LEN) begin
                            rx_ok_next     = ok_chk;
                            heard_mac_next = mac_chk;
                            rx_pos_next    = rx_pos_inc;
                        end
                        if (rx_end) begin
                            if (rx_pos_next >= arp_pkg::FRAME_LEN && rx_ok_next) begin
                                out_valid_next = 1'b1;
                                kind_next      = arp_pkg::KIND_FOUND;
                                tx_byte_next   = 8'h00;
                                tx_end_next    = 1'b0;
                                found_mac_next = heard_mac_next;
                                run_last_next  = 1'b1;
                                waiting_next   = 1'b0;
                            end
                            rx_pos_next = '0;
                            rx_ok_next  = 1'b1;
                        end
                    end
                end
                arp_pkg::CMD_TICK:
                begin
                    if (waiting_reg) begin
                        ticks_left_next = ticks_dec;
                        if (ticks_dec == '0) begin
                            waiting_next   = 1'b0;
                            rx_pos_next    = '0;
                            rx_ok_next     = 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = arp_pkg::KIND_FAILED;
                            tx_byte_next   = 8'h00;
                            tx_end_next    = 1'b0;
                            found_mac_next = '0;
                            run_last_next  = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            local_mac_reg  <= '0;
            local_ip_reg   <= '0;
            timeout_ms_reg <= arp_pkg::TMO_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                arp_pkg::REG_LOCAL_MAC:  local_mac_reg  <= cfg_data;
                arp_pkg::REG_LOCAL_IP:   local_ip_reg   <= cfg_data[31:0];
                arp_pkg::REG_TIMEOUT_MS: timeout_ms_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            waiting_reg     <= 1'b0;
            target_addr_reg <= '0;
            ticks_left_reg  <= '0;
            rx_pos_reg      <= '0;
            rx_ok_reg       <= 1'b1;
            heard_mac_reg   <= '0;
            tx_active_reg   <= 1'b0;
            tx_pos_reg      <= '0;
            tx_fail_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            waiting_reg     <= waiting_next;
            target_addr_reg <= target_addr_next;
            ticks_left_reg  <= ticks_left_next;
            rx_pos_reg      <= rx_pos_next;
            rx_ok_reg       <= rx_ok_next;
            heard_mac_reg   <= heard_mac_next;
            tx_active_reg   <= tx_active_next;
            tx_pos_reg      <= tx_pos_next;
            tx_fail_reg     <= tx_fail_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        tx_byte_reg   <= tx_byte_next;
        tx_end_reg    <= tx_end_next;
        found_mac_reg <= found_mac_next;
        run_last_reg  <= run_last_next;
    end

endmodule

`default_nettype wire
